// ===== hw/rtl/pendulum_integration_step_top_defines.svh =====
// Assertion macros for the pendulum step block.
// Used by pendulum_integration_step_top; define NO_ASSERTIONS to drop them.
`ifndef PENDULUM_INTEGRATION_STEP_TOP_DEFINES_SVH
`define PENDULUM_INTEGRATION_STEP_TOP_DEFINES_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication, checked out of reset
`define PIS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pis: same-cycle check failed");
// next-cycle implication, checked out of reset
`define PIS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pis: next-cycle check failed");
`else
`define PIS_ASSERT_IMP(lbl, ante, cons)
`define PIS_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ===== hw/rtl/pis_pkg.sv =====
// Shared types, constants and fixed-point helpers for the pendulum step block.
// No dependencies.
`default_nettype none

package pis_pkg;

  // wide signed working value for sums and rounded products
  typedef logic signed [67:0] pis_wide_t;

  // status from a multi-cycle unit
  typedef struct packed {
    logic done;
    logic clip;
  } pis_stat_t;

  // angle constants, 36 fraction bits
  localparam logic [38:0] TwoPiQ36  = 39'h6487ED5111;
  localparam logic [38:0] PiQ36     = 39'h3243F6A889;
  localparam logic [38:0] HalfPiQ36 = 39'h1921FB5444;
  // CORDIC start gain, 30 fraction bits
  localparam logic [29:0] GainQ30   = 30'h26DD3B6A;

  localparam pis_wide_t SatMax = 68'sd2147483647;
  localparam pis_wide_t SatMin = -68'sd2147483648;

  // register indexes
  localparam logic [2:0] CfgBaseX      = 3'd0;
  localparam logic [2:0] CfgBaseY      = 3'd1;
  localparam logic [2:0] CfgRodLength  = 3'd2;
  localparam logic [2:0] CfgGravity    = 3'd3;
  localparam logic [2:0] CfgDrag       = 3'd4;
  localparam logic [2:0] CfgBobMass    = 3'd5;
  localparam logic [2:0] CfgMethod     = 3'd6;
  localparam logic [2:0] CfgStartAngle = 3'd7;

  // round half up, then arithmetic shift right
  function automatic pis_wide_t rsh(input pis_wide_t v, input int unsigned s);
    pis_wide_t half;
    half = pis_wide_t'(1) <<< (s - 1);
    return (v + half) >>> s;
  endfunction

  function automatic logic signed [31:0] sat32(input pis_wide_t v);
    logic signed [31:0] r;
    if (v > SatMax) r = 32'sh7FFFFFFF;
    else if (v < SatMin) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic clip32(input pis_wide_t v);
    return (v > SatMax) || (v < SatMin);
  endfunction

  // arctan(2^-i), 30 fraction bits
  function automatic logic [29:0] atan_q30(input logic [4:0] i);
    logic [29:0] a;
    case (i)
      5'd0:  a = 30'h3243F6A8;
      5'd1:  a = 30'h1DAC6705;
      5'd2:  a = 30'h0FADBAFC;
      5'd3:  a = 30'h07F56EA6;
      5'd4:  a = 30'h03FEAB76;
      5'd5:  a = 30'h01FFD55B;
      5'd6:  a = 30'h00FFFAAA;
      5'd7:  a = 30'h007FFF55;
      5'd8:  a = 30'h003FFFEA;
      5'd9:  a = 30'h001FFFFD;
      5'd10: a = 30'h000FFFFF;
      5'd11: a = 30'h0007FFFF;
      5'd12: a = 30'h0003FFFF;
      5'd13: a = 30'h0001FFFF;
      5'd14: a = 30'h0000FFFF;
      5'd15: a = 30'h00007FFF;
      5'd16: a = 30'h00003FFF;
      5'd17: a = 30'h00001FFF;
      5'd18: a = 30'h00000FFF;
      5'd19: a = 30'h000007FF;
      5'd20: a = 30'h000003FF;
      5'd21: a = 30'h000001FF;
      5'd22: a = 30'h000000FF;
      5'd23: a = 30'h0000007F;
      5'd24: a = 30'h0000003F;
      5'd25: a = 30'h0000001F;
      5'd26: a = 30'h0000000F;
      5'd27: a = 30'h00000007;
      5'd28: a = 30'h00000003;
      5'd29: a = 30'h00000001;
      default: a = 30'h0;
    endcase
    return a;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/pis_div.sv =====
// Restoring divider: saturate(num * 2^FracBits / den), truncated toward zero.
// One quotient bit per cycle. Depends on pis_pkg.
`default_nettype none

module pis_div #(
  parameter int FracBits = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic signed [31:0]  num_i,
  input  logic [30:0]         den_i,
  output logic signed [31:0]  quo_o,
  output pis_pkg::pis_stat_t  stat_o
);
  import pis_pkg::*;

  localparam int NW   = 32 + FracBits;
  localparam int CntW = $clog2(NW + 1);

  logic [NW-1:0]   mag_q;
  logic [30:0]     den_q;
  logic [31:0]     rem_q;
  logic [CntW-1:0] cnt_q;
  logic            neg_q, busy_q, done_q;

  logic [31:0] abs_num, rem_sh, den_ext;
  logic        ge;
  pis_wide_t   q_signed;

  assign abs_num = num_i[31] ? 32'(-num_i) : 32'(num_i);
  assign rem_sh  = {rem_q[30:0], mag_q[NW-1]};
  assign den_ext = {1'b0, den_q};
  assign ge      = rem_sh >= den_ext;

  // busy/done control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == CntW'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(NW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CntW'(1);
        if (cnt_q == CntW'(1)) busy_q <= 1'b0;
      end
    end
  end

  // datapath: dividend shifts out, quotient shifts in
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mag_q <= {abs_num, {FracBits{1'b0}}};
      den_q <= (den_i == '0) ? 31'd1 : den_i;
      rem_q <= '0;
      neg_q <= num_i[31];
    end else if (busy_q) begin
      rem_q <= ge ? rem_sh - den_ext : rem_sh;
      mag_q <= {mag_q[NW-2:0], ge};
    end
  end

  assign q_signed    = neg_q ? -pis_wide_t'({1'b0, mag_q}) : pis_wide_t'({1'b0, mag_q});
  assign quo_o       = sat32(q_signed);
  assign stat_o.done = done_q;
  assign stat_o.clip = clip32(q_signed);

endmodule

`default_nettype wire

// ===== hw/rtl/pis_trig.sv =====
// Sine and cosine of a fixed-point angle: modulo-2pi reduction by a reciprocal
// quotient estimate and one correction, quadrant fold, then one CORDIC rotation
// per cycle. Uses pis_pkg.
`default_nettype none

module pis_trig #(
  parameter int FracBits    = 16,
  parameter int CordicSteps = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic signed [31:0]  ang_i,
  output logic signed [31:0]  sin_o,
  output logic signed [31:0]  cos_o,
  output pis_pkg::pis_stat_t  stat_o
);
  import pis_pkg::*;

  localparam int Sh       = 36 - FracBits;
  localparam int RW       = 68 - FracBits;
  localparam int RedSteps = 3;
  localparam int CntW     = $clog2(RedSteps + 1);
  localparam int OutShift = 30 - FracBits;
  // quotient of the reduction fits RW-38 bits
  localparam int QW       = RW - 38;

  localparam logic signed [41:0] Pi42     = {3'b000, PiQ36};
  localparam logic signed [41:0] TwoPi42  = {3'b000, TwoPiQ36};
  localparam logic signed [41:0] HalfPi42 = {3'b000, HalfPiQ36};
  // 2^(Sh+32) / 2pi, rounded down: estimate is the quotient or one less
  localparam logic [31:0]        Recip    = 32'((64'd1 << (Sh + 32)) / 64'(TwoPiQ36));
  localparam logic [RW-1:0]      TwoPiRw  = RW'(TwoPiQ36);

  typedef enum logic [4:0] {
    T_IDLE = 5'b00001,
    T_RED  = 5'b00010,
    T_PREP = 5'b00100,
    T_ROT  = 5'b01000,
    T_DONE = 5'b10000
  } trig_state_e;

  trig_state_e        st_q;
  logic [RW-1:0]      mag_q;
  logic [QW-1:0]      q_q;
  logic [CntW-1:0]    cnt_q;
  logic [4:0]         i_q;
  logic               neg_q, negcos_q;
  logic signed [32:0] x_q, y_q, z_q;

  logic [31:0]        abs_ang, red_abs;
  logic [63:0]        red_prod;
  logic [RW-1:0]      red_sub;
  logic signed [41:0] r0, r1, r2;
  logic               fold;
  pis_wide_t          z0, tx, tc, ty;
  logic signed [32:0] dx, dy, at;

  assign abs_ang = ang_i[31] ? 32'(-ang_i) : 32'(ang_i);

  // quotient estimate and its multiple of 2pi
  assign red_abs  = mag_q[RW-1:Sh];
  assign red_prod = 64'(red_abs) * 64'(Recip);
  assign red_sub  = RW'(q_q) * TwoPiRw;

  // wrap into [-pi, pi], fold into [-pi/2, pi/2]
  always_comb begin
    r0   = neg_q ? -{3'b000, mag_q[38:0]} : {3'b000, mag_q[38:0]};
    if (r0 > Pi42) r1 = r0 - TwoPi42;
    else if (r0 < -Pi42) r1 = r0 + TwoPi42;
    else r1 = r0;
    fold = 1'b1;
    if (r1 > HalfPi42) r2 = Pi42 - r1;
    else if (r1 < -HalfPi42) r2 = -Pi42 - r1;
    else begin
      r2   = r1;
      fold = 1'b0;
    end
    z0 = rsh(pis_wide_t'(r2), 6);
  end

  assign dx = y_q >>> i_q;
  assign dy = x_q >>> i_q;
  assign at = {3'b000, atan_q30(i_q)};

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= T_IDLE;
      cnt_q <= '0;
      i_q   <= '0;
    end else begin
      unique case (st_q)
        T_IDLE: if (start_i) begin
          st_q  <= T_RED;
          cnt_q <= CntW'(RedSteps);
        end
        T_RED: begin
          cnt_q <= cnt_q - CntW'(1);
          if (cnt_q == CntW'(1)) st_q <= T_PREP;
        end
        T_PREP: begin
          st_q <= T_ROT;
          i_q  <= '0;
        end
        T_ROT: begin
          i_q <= i_q + 5'd1;
          if (i_q == 5'(CordicSteps - 1)) st_q <= T_DONE;
        end
        T_DONE: st_q <= T_IDLE;
        default: st_q <= T_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (st_q == T_IDLE && start_i) begin
      mag_q <= RW'(abs_ang) << Sh;
      neg_q <= ang_i[31];
    end
    // estimate, subtract, then one correcting subtract
    if (st_q == T_RED) begin
      if (cnt_q == CntW'(RedSteps)) q_q <= red_prod[32 +: QW];
      else if (cnt_q == CntW'(2)) mag_q <= mag_q - red_sub;
      else if (mag_q >= TwoPiRw) mag_q <= mag_q - TwoPiRw;
    end
    if (st_q == T_PREP) begin
      x_q      <= {3'b000, GainQ30};
      y_q      <= '0;
      z_q      <= z0[32:0];
      negcos_q <= fold;
    end
    if (st_q == T_ROT) begin
      if (!z_q[32]) begin
        x_q <= x_q - dx;
        y_q <= y_q + dy;
        z_q <= z_q - at;
      end else begin
        x_q <= x_q + dx;
        y_q <= y_q - dy;
        z_q <= z_q + at;
      end
    end
  end

  // round back to the output format
  assign tx = rsh(pis_wide_t'(x_q), OutShift);
  assign tc = negcos_q ? -tx : tx;
  assign ty = rsh(pis_wide_t'(y_q), OutShift);
  assign cos_o       = sat32(tc);
  assign sin_o       = sat32(ty);
  assign stat_o.done = (st_q == T_DONE);
  assign stat_o.clip = clip32(tc) || clip32(ty);

endmodule

`default_nettype wire

// ===== hw/rtl/pendulum_integration_step_top.sv =====
// Damped pendulum stepper: sequencer, shared multiplier, state and config regs.
// Depends on pis_pkg, pis_trig, pis_div and the assertion macro header.
//
//   channel | signals                                   | dir
//   --------+-------------------------------------------+-----
//   in      | in_valid_i, in_ready_o, time_step_i       | in
//   out     | out_valid_o, out_ready_i, angle/rate/...  | out
//   cfg     | cfg_valid_i, cfg_ready_o, cfg_index_i/data| in
//
// One item at a time. The radix-2 divider (used twice per item) and the trig
// unit (once for Verlet, twice for Euler) take most of an item's time; each
// multiply is issued in one phase and its registered product is taken in the
// next phase of its step, on one shared multiplier.
// Reset clears the state and loads register defaults. The result is held
// until taken; no new item is accepted until then. Config writes always ready.
`default_nettype none
`include "pendulum_integration_step_top_defines.svh"

module pendulum_integration_step_top #(
  parameter int CORDIC_STEPS = 16,
  parameter int FRAC_BITS    = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [15:0]        time_step_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] angle_out_o,
  output logic signed [31:0] rate_out_o,
  output logic signed [31:0] accel_out_o,
  output logic signed [31:0] bob_x_o,
  output logic signed [31:0] bob_y_o,
  output logic               saturated_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i
);
  import pis_pkg::*;

  typedef enum logic [16:0] {
    S_IDLE = 17'd1,
    S_V1   = 17'd2,
    S_V2   = 17'd4,
    S_V3   = 17'd8,
    S_TRIG = 17'd16,
    S_A1   = 17'd32,
    S_A2   = 17'd64,
    S_A3   = 17'd128,
    S_A4   = 17'd256,
    S_A5   = 17'd512,
    S_A6   = 17'd1024,
    S_V4   = 17'd2048,
    S_E1   = 17'd4096,
    S_E2   = 17'd8192,
    S_B1   = 17'd16384,
    S_B2   = 17'd32768,
    S_OUT  = 17'd65536
  } seq_state_e;

  seq_state_e state_q;
  logic       ph_q, pass_q, clip_q;
  logic [15:0] dt_q;

  // config registers
  logic signed [31:0] base_x_q, base_y_q;
  logic [30:0]        len_q, grav_q, drag_q, mass_q;
  logic               method_q;

  // motion state and working registers
  logic signed [31:0] angle_q, rate_q, accel_q;
  logic signed [31:0] na_q, nw_q, nacc_q, tmp_q, dacc_q, s_q, c_q, bx_q, by_q;
  logic signed [33:0] acc_q;
  logic signed [65:0] prod_q;

  logic signed [32:0] mul_a, mul_b, dt_s, abs_rate;
  int unsigned        sh;
  pis_wide_t          addend, pw, sum, a6_sum;
  logic signed [31:0] post_val;
  logic               post_clip;

  logic               trig_start, div_start;
  logic signed [31:0] trig_ang, sin_v, cos_v, div_q;
  pis_stat_t          trig_st, div_st;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_OUT);
  assign cfg_ready_o = 1'b1;

  assign dt_s     = {17'b0, dt_q};
  assign abs_rate = rate_q[31] ? -{rate_q[31], rate_q} : {rate_q[31], rate_q};

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      S_V1: begin mul_a = {accel_q[31], accel_q}; mul_b = dt_s; end
      S_V2: begin mul_a = {rate_q[31], rate_q}; mul_b = dt_s; end
      S_V3: begin mul_a = {tmp_q[31], tmp_q}; mul_b = dt_s; end
      S_V4: begin
        mul_a = {accel_q[31], accel_q} + {nacc_q[31], nacc_q};
        mul_b = dt_s;
      end
      S_E1: begin mul_a = {nacc_q[31], nacc_q}; mul_b = dt_s; end
      S_E2: begin mul_a = {nw_q[31], nw_q}; mul_b = dt_s; end
      S_A1: begin mul_a = {rate_q[31], rate_q}; mul_b = abs_rate; end
      S_A2: begin mul_a = {tmp_q[31], tmp_q}; mul_b = {2'b00, drag_q}; end
      S_A4: begin mul_a = {s_q[31], s_q}; mul_b = {2'b00, grav_q}; end
      S_B1: begin mul_a = {s_q[31], s_q}; mul_b = {2'b00, len_q}; end
      S_B2: begin mul_a = {c_q[31], c_q}; mul_b = {2'b00, len_q}; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  // rounding shift, addend and saturation after the product register
  always_comb begin
    sh     = 16;
    addend = '0;
    unique case (state_q)
      S_V3: begin sh = 17; addend = pis_wide_t'(angle_q) + pis_wide_t'(acc_q); end
      S_V4: begin sh = 17; addend = pis_wide_t'(rate_q); end
      S_E1: addend = pis_wide_t'(rate_q);
      S_E2: addend = pis_wide_t'(angle_q);
      S_A1, S_A4: sh = FRAC_BITS;
      S_A2: sh = FRAC_BITS + 1;
      S_B1: begin sh = FRAC_BITS; addend = pis_wide_t'(base_x_q); end
      S_B2: begin sh = FRAC_BITS; addend = pis_wide_t'(base_y_q); end
      default: begin sh = 16; addend = '0; end
    endcase
    pw        = rsh(pis_wide_t'(prod_q), sh);
    sum       = addend + pw;
    post_val  = sat32(sum);
    post_clip = clip32(sum);
    a6_sum    = -pis_wide_t'(tmp_q) - pis_wide_t'(dacc_q);
  end

  assign trig_start = (state_q == S_TRIG) && !ph_q;
  assign trig_ang   = (method_q && !pass_q) ? angle_q : na_q;
  assign div_start  = ((state_q == S_A3) || (state_q == S_A5)) && !ph_q;

  pis_trig #(
    .FracBits    (FRAC_BITS),
    .CordicSteps (CORDIC_STEPS)
  ) u_trig (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (trig_start),
    .ang_i   (trig_ang),
    .sin_o   (sin_v),
    .cos_o   (cos_v),
    .stat_o  (trig_st)
  );

  pis_div #(
    .FracBits (FRAC_BITS)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (tmp_q),
    .den_i   ((state_q == S_A3) ? mass_q : len_q),
    .quo_o   (div_q),
    .stat_o  (div_st)
  );

  // multiplier output register
  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
  end

  // working registers, loaded as each step completes
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) dt_q <= time_step_i;
    if (ph_q) begin
      unique case (state_q)
        S_V1, S_A1, S_A2, S_A4: tmp_q <= post_val;
        S_V2: acc_q <= pw[33:0];
        S_V3, S_E2: na_q <= post_val;
        S_V4, S_E1: nw_q <= post_val;
        S_B1: bx_q <= post_val;
        S_B2: by_q <= post_val;
        S_TRIG: if (trig_st.done) begin s_q <= sin_v; c_q <= cos_v; end
        S_A3: if (div_st.done) dacc_q <= div_q;
        S_A5: if (div_st.done) tmp_q <= div_q;
        default: ;
      endcase
    end
    if (state_q == S_A6) nacc_q <= sat32(a6_sum);
  end

  // sequencer, config and motion state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      ph_q     <= 1'b0;
      pass_q   <= 1'b0;
      clip_q   <= 1'b0;
      base_x_q <= '0;
      base_y_q <= '0;
      len_q    <= 31'd65536;
      grav_q   <= 31'd642908;
      drag_q   <= '0;
      mass_q   <= 31'd65536;
      method_q <= 1'b0;
      angle_q  <= '0;
      rate_q   <= '0;
      accel_q  <= '0;
    end else begin
      // register writes
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CfgBaseX:      base_x_q <= cfg_data_i;
          CfgBaseY:      base_y_q <= cfg_data_i;
          CfgRodLength:  len_q    <= cfg_data_i[30:0];
          CfgGravity:    grav_q   <= cfg_data_i[30:0];
          CfgDrag:       drag_q   <= cfg_data_i[30:0];
          CfgBobMass:    mass_q   <= cfg_data_i[30:0];
          CfgMethod:     method_q <= cfg_data_i[0];
          CfgStartAngle: begin
            angle_q <= cfg_data_i;
            rate_q  <= '0;
            accel_q <= '0;
          end
          default: ;
        endcase
      end

      unique case (state_q)
        S_IDLE: if (in_valid_i) begin
          clip_q  <= 1'b0;
          pass_q  <= 1'b0;
          ph_q    <= 1'b0;
          state_q <= method_q ? S_TRIG : S_V1;
        end
        S_TRIG: begin
          if (!ph_q) ph_q <= 1'b1;
          else if (trig_st.done) begin
            ph_q    <= 1'b0;
            clip_q  <= clip_q | trig_st.clip;
            state_q <= (method_q && pass_q) ? S_B1 : S_A1;
          end
        end
        S_A3, S_A5: begin
          if (!ph_q) ph_q <= 1'b1;
          else if (div_st.done) begin
            ph_q    <= 1'b0;
            clip_q  <= clip_q | div_st.clip;
            state_q <= (state_q == S_A3) ? S_A4 : S_A6;
          end
        end
        S_A6: begin
          clip_q  <= clip_q | clip32(a6_sum);
          state_q <= method_q ? S_E1 : S_V4;
        end
        S_OUT: if (out_ready_i) begin
          angle_q <= na_q;
          rate_q  <= nw_q;
          accel_q <= nacc_q;
          state_q <= S_IDLE;
        end
        // multiply steps: issue, then take the registered product
        default: begin
          if (!ph_q) ph_q <= 1'b1;
          else begin
            ph_q <= 1'b0;
            if (state_q != S_V2) clip_q <= clip_q | post_clip;
            unique case (state_q)
              S_V1: state_q <= S_V2;
              S_V2: state_q <= S_V3;
              S_V3: state_q <= S_TRIG;
              S_A1: state_q <= S_A2;
              S_A2: state_q <= S_A3;
              S_A4: state_q <= S_A5;
              S_V4: state_q <= S_B1;
              S_E1: state_q <= S_E2;
              S_E2: begin
                state_q <= S_TRIG;
                pass_q  <= 1'b1;
              end
              S_B1: state_q <= S_B2;
              S_B2: state_q <= S_OUT;
              default: state_q <= S_IDLE;
            endcase
          end
        end
      endcase
    end
  end

  assign angle_out_o = na_q;
  assign rate_out_o  = nw_q;
  assign accel_out_o = nacc_q;
  assign bob_x_o     = bx_q;
  assign bob_y_o     = by_q;
  assign saturated_o = clip_q;

  // checks
  `PIS_ASSERT_IMP(a_ready_excl_valid, in_ready_o, !out_valid_o)
  `PIS_ASSERT_NXT(a_accept_busy, in_valid_i && in_ready_o, !in_ready_o && !out_valid_o)
  `PIS_ASSERT_NXT(a_out_then_idle, out_valid_o && out_ready_i, in_ready_o)

endmodule

`default_nettype wire
